>>> rtl/core/plar_pkg.sv
`default_nettype none
package plar_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int RAD_W      = SQ_W + 2;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int LEN_W      = 48;
  localparam int DVD_W      = 64;
  localparam int RATIO_BITS = 24;
  localparam int RATIO_W    = RATIO_BITS + 1;
  localparam int PROD_W     = DIFF_W + RATIO_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      last_out;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/core/plar_sqrt.sv
`default_nettype none
module plar_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [plar_pkg::RAD_W-1:0]  rad,
  output logic                             done,
  output logic [plar_pkg::ROOT_W-1:0]      root
);
  import plar_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]    rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;

  // One result bit per cycle: bring down two radicand bits, try root*4+1.
  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(ROOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r <= {rad_r[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

>>> rtl/core/plar_div.sv
`default_nettype none
module plar_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [plar_pkg::DVD_W-1:0]  dividend,
  input  wire logic [plar_pkg::LEN_W-1:0]  divisor,
  output logic                             done,
  output logic [plar_pkg::DVD_W-1:0]       quotient
);
  import plar_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [LEN_W-1:0] div_r;
  logic [LEN_W:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LEN_W:0]   rem_sh;

  assign rem_sh = {rem_r[LEN_W-1:0], dvd_r[DVD_W-1]};

  // Restoring division; quotient bits shift in where dividend bits leave.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_r <= rem_sh - {1'b0, div_r};
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

>>> rtl/core/polyline_arclength_resample.sv
`default_nettype none
// Loads one polyline vertex per cycle while busy is low; the word flagged
// last_point starts resampling and raises busy. The block then emits as many
// words as it loaded, one strobe per word, and the receiver cannot stall.
// Fewer than three points, or zero total length, are replayed unchanged from
// the store, one memory read per word. Otherwise a first pass sums the
// segment lengths (memory read, differences, squares, square root), spacing
// takes a divide, and a second pass repeats the per-segment work and forms
// the interpolation ratio of each interior point on a nonzero-length segment
// with the same divider, which is shared with the spacing divide.
module polyline_arclength_resample #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire plar_pkg::in_word_t  in_data,
  output logic                     out_valid,
  output plar_pkg::out_word_t      out_data
);
  import plar_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [4:0] {
    S_LOAD, S_PREP, S_RD0, S_RD0W, S_RDN, S_RDNW, S_DIFF, S_SQ, S_SQRT, S_SQW,
    S_SPD, S_SPW, S_WALK, S_RDIV, S_RW, S_MUL, S_EMIT, S_TRD, S_TRW
  } state_t;

  state_t state_r;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rdata_r;
  logic [AW-1:0]        rd_addr;

  logic [CW-1:0] cnt_r, n_r, idx_r;
  logic [AW-1:0] k_r;
  logic          pass2_r;

  logic signed [COORD_W-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic [LEN_W-1:0]          total_r, spacing_r, cum_r, target_r;
  logic [ROOT_W-1:0]         norm_r;
  logic [RATIO_W-1:0]        ratio_r;
  logic [PROD_W-1:0]         px_r, py_r;
  logic [DVD_W-1:0]          div_a_r;
  logic [LEN_W-1:0]          div_b_r;

  logic      out_valid_r;
  out_word_t out_data_r;

  logic                   accept;
  logic                   sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]      sq_root;
  logic [DVD_W-1:0]       dv_q;
  logic [DIFF_W-1:0]      magx, magy;
  logic signed [DIFF_W:0] dx_e, dy_e;
  logic [LEN_W-1:0]       total_nxt, cum_nxt, t_raw, t_clip;
  logic                   last_seg;
  logic [PROD_W:0]        offx_sum, offy_sum;
  logic signed [COORD_W+1:0] offx, offy, endx, endy, resx, resy;

  assign accept   = start && (state_r == S_LOAD);
  assign busy     = (state_r != S_LOAD);
  assign sq_start = (state_r == S_SQRT);
  assign dv_start = (state_r == S_SPD) || (state_r == S_RDIV);

  always_comb begin
    case (state_r)
      S_RDN:   rd_addr = k_r + 1'b1;
      S_TRD:   rd_addr = idx_r[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && (cnt_r < CW'(MAX_POINTS))) begin
      mem[cnt_r[AW-1:0]] <= {in_data.point_y, in_data.point_x};
    end
    rdata_r <= mem[rd_addr];
  end

  assign dx_e = {dx_r[DIFF_W-1], dx_r};
  assign dy_e = {dy_r[DIFF_W-1], dy_r};
  assign magx = dx_e[DIFF_W] ? DIFF_W'(-dx_e) : DIFF_W'(dx_e);
  assign magy = dy_e[DIFF_W] ? DIFF_W'(-dy_e) : DIFF_W'(dy_e);

  assign total_nxt = total_r + LEN_W'(sq_root);
  assign cum_nxt   = cum_r + LEN_W'(sq_root);
  assign last_seg  = (CW'(k_r) + CW'(2)) == n_r;
  assign t_raw     = cum_r - target_r;
  assign t_clip    = (t_raw > LEN_W'(norm_r)) ? LEN_W'(norm_r) : t_raw;

  // Offset is rounded by magnitude, then applied toward the segment start.
  assign offx_sum = {1'b0, px_r} + (PROD_W+1)'(1 << (RATIO_BITS - 1));
  assign offy_sum = {1'b0, py_r} + (PROD_W+1)'(1 << (RATIO_BITS - 1));
  assign offx = $signed({1'b0, offx_sum[RATIO_BITS +: COORD_W+1]});
  assign offy = $signed({1'b0, offy_sum[RATIO_BITS +: COORD_W+1]});
  assign endx = (COORD_W+2)'(cur_x_r);
  assign endy = (COORD_W+2)'(cur_y_r);
  assign resx = dx_r[DIFF_W-1] ? endx - offx : endx + offx;
  assign resy = dy_r[DIFF_W-1] ? endy - offy : endy + offy;

  plar_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (RAD_W'(sqx_r) + RAD_W'(sqy_r)),
    .done  (sq_done),
    .root  (sq_root)
  );

  plar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      pass2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (cnt_r < CW'(MAX_POINTS)) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_data.last_point) begin
              n_r     <= cnt_r + CW'(cnt_r < CW'(MAX_POINTS));
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (n_r < CW'(3)) begin
            idx_r   <= '0;
            state_r <= S_TRD;
          end else begin
            pass2_r <= 1'b0;
            total_r <= '0;
            state_r <= S_RD0;
          end
        end
        S_RD0:  state_r <= S_RD0W;
        S_RD0W: begin
          prev_x_r <= rdata_r[COORD_W-1:0];
          prev_y_r <= rdata_r[2*COORD_W-1:COORD_W];
          k_r      <= '0;
          if (pass2_r) begin
            out_valid_r         <= 1'b1;
            out_data_r.out_x    <= rdata_r[COORD_W-1:0];
            out_data_r.out_y    <= rdata_r[2*COORD_W-1:COORD_W];
            out_data_r.last_out <= 1'b0;
          end
          state_r <= S_RDN;
        end
        S_RDN:  state_r <= S_RDNW;
        S_RDNW: begin
          cur_x_r <= rdata_r[COORD_W-1:0];
          cur_y_r <= rdata_r[2*COORD_W-1:COORD_W];
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          dx_r    <= DIFF_W'(prev_x_r) - DIFF_W'(cur_x_r);
          dy_r    <= DIFF_W'(prev_y_r) - DIFF_W'(cur_y_r);
          state_r <= S_SQ;
        end
        S_SQ: begin
          sqx_r   <= magx * magx;
          sqy_r   <= magy * magy;
          state_r <= S_SQRT;
        end
        S_SQRT: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            norm_r <= sq_root;
            if (pass2_r) begin
              cum_r   <= cum_nxt;
              state_r <= S_WALK;
            end else begin
              total_r <= total_nxt;
              if (!last_seg) begin
                prev_x_r <= cur_x_r;
                prev_y_r <= cur_y_r;
                k_r      <= k_r + 1'b1;
                state_r  <= S_RDN;
              end else if (total_nxt == '0) begin
                idx_r   <= '0;
                state_r <= S_TRD;
              end else begin
                div_a_r <= DVD_W'(total_nxt);
                div_b_r <= LEN_W'(n_r - 1'b1);
                state_r <= S_SPD;
              end
            end
          end
        end
        S_SPD: state_r <= S_SPW;
        S_SPW: begin
          if (dv_done) begin
            spacing_r <= dv_q[LEN_W-1:0];
            target_r  <= dv_q[LEN_W-1:0];
            cum_r     <= '0;
            idx_r     <= CW'(1);
            pass2_r   <= 1'b1;
            state_r   <= S_RD0;
          end
        end
        S_WALK: begin
          if ((idx_r < n_r - 1'b1) && (cum_r >= target_r)) begin
            if (norm_r == '0) begin
              // A zero-length segment places the point on its end vertex.
              out_valid_r         <= 1'b1;
              out_data_r.out_x    <= cur_x_r;
              out_data_r.out_y    <= cur_y_r;
              out_data_r.last_out <= 1'b0;
              idx_r               <= idx_r + 1'b1;
              target_r            <= target_r + spacing_r;
            end else begin
              div_a_r <= DVD_W'(t_clip) << RATIO_BITS;
              div_b_r <= LEN_W'(norm_r);
              state_r <= S_RDIV;
            end
          end else if (last_seg) begin
            state_r <= S_TRD;
          end else begin
            prev_x_r <= cur_x_r;
            prev_y_r <= cur_y_r;
            k_r      <= k_r + 1'b1;
            state_r  <= S_RDN;
          end
        end
        S_RDIV: state_r <= S_RW;
        S_RW: begin
          if (dv_done) begin
            ratio_r <= dv_q[RATIO_W-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= magx * ratio_r;
          py_r    <= magy * ratio_r;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r         <= 1'b1;
          out_data_r.out_x    <= resx[COORD_W-1:0];
          out_data_r.out_y    <= resy[COORD_W-1:0];
          out_data_r.last_out <= 1'b0;
          idx_r               <= idx_r + 1'b1;
          target_r            <= target_r + spacing_r;
          state_r             <= S_WALK;
        end
        S_TRD: state_r <= S_TRW;
        S_TRW: begin
          out_valid_r         <= 1'b1;
          out_data_r.out_x    <= rdata_r[COORD_W-1:0];
          out_data_r.out_y    <= rdata_r[2*COORD_W-1:COORD_W];
          out_data_r.last_out <= (idx_r == n_r - 1'b1);
          if (idx_r == n_r - 1'b1) begin
            cnt_r   <= '0;
            pass2_r <= 1'b0;
            state_r <= S_LOAD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_out |=> !out_valid)
    else $error("word strobed right after the final word");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last_point |=> busy)
    else $error("final vertex did not start resampling");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (idx_r < n_r) && (idx_r != '0))
    else $error("walk index outside the interior");

endmodule
`default_nettype wire

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plar_pkg::*;

  localparam int MAX_PTS = 64;

  // Tracks loaded vertices and queues the resampled words each polyline produces.
  class resample_scoreboard;
    longint vx[MAX_PTS];
    longint vy[MAX_PTS];
    int unsigned loaded;
    out_word_t resampled_q[$];
    int errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    // Exact floor of the Euclidean segment length in raw fixed-point units.
    function longint unsigned seg_length(longint dx, longint dy);
      logic [131:0] sum_sq;
      logic [131:0] ax;
      logic [131:0] ay;
      logic [131:0] mid_sq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sum_sq = ax * ax + ay * ay;
      lo = 0;
      hi = 64'd1 << 33;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        mid_sq = 132'(mid) * 132'(mid);
        if (mid_sq <= sum_sq) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function longint lerp_toward(longint p0, longint p1, longint unsigned t,
                                 longint unsigned norm);
      longint d;
      longint unsigned mag;
      longint unsigned ratio;
      longint unsigned offs;
      d = p0 - p1;
      mag = (d < 0) ? -d : d;
      ratio = (t << RATIO_BITS) / norm;
      offs = (mag * ratio + (64'd1 << (RATIO_BITS - 1))) >> RATIO_BITS;
      return (d < 0) ? p1 - longint'(offs) : p1 + longint'(offs);
    endfunction

    function void resample_polyline(int unsigned n);
      longint rx[MAX_PTS];
      longint ry[MAX_PTS];
      longint unsigned total;
      longint unsigned step;
      longint unsigned run_len;
      longint unsigned norm;
      longint unsigned t;
      int unsigned idx;
      out_word_t w;
      for (int k = 0; k < n; k++) begin
        rx[k] = vx[k];
        ry[k] = vy[k];
      end
      if (n >= 3) begin
        total = 0;
        for (int k = 0; k + 1 < n; k++)
          total += seg_length(vx[k+1] - vx[k], vy[k+1] - vy[k]);
        if (total != 0) begin
          step = total / (n - 1);
          run_len = 0;
          idx = 1;
          for (int k = 0; k + 1 < n; k++) begin
            norm = seg_length(vx[k+1] - vx[k], vy[k+1] - vy[k]);
            run_len += norm;
            while (idx < n - 1 && run_len >= idx * step) begin
              t = run_len - idx * step;
              if (norm == 0) begin
                rx[idx] = vx[k+1];
                ry[idx] = vy[k+1];
              end else begin
                if (t > norm) t = norm;
                rx[idx] = lerp_toward(vx[k], vx[k+1], t, norm);
                ry[idx] = lerp_toward(vy[k], vy[k+1], t, norm);
              end
              idx++;
            end
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        w.out_x = rx[k][31:0];
        w.out_y = ry[k][31:0];
        w.last_out = (k + 1 == n);
        resampled_q.push_back(w);
      end
    endfunction

    function void note_vertex(in_word_t w);
      if (loaded < MAX_PTS) begin
        vx[loaded] = longint'(w.point_x);
        vy[loaded] = longint'(w.point_y);
        loaded++;
      end
      if (w.last_point) begin
        resample_polyline(loaded);
        loaded = 0;
      end
    endfunction

    function void check_word(out_word_t w);
      out_word_t e;
      if (resampled_q.size() == 0) begin
        $error("unexpected output word x=%0d y=%0d last=%0b", w.out_x, w.out_y, w.last_out);
        errors++;
        return;
      end
      e = resampled_q.pop_front();
      if (w.out_x !== e.out_x) begin
        $error("out_x: expected %0d, got %0d", e.out_x, w.out_x);
        errors++;
      end
      if (w.out_y !== e.out_y) begin
        $error("out_y: expected %0d, got %0d", e.out_y, w.out_y);
        errors++;
      end
      if (w.last_out !== e.last_out) begin
        $error("last_out: expected %0b, got %0b", e.last_out, w.last_out);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_data;
  logic out_valid;
  out_word_t out_data;

  resample_scoreboard sb;
  int idle_pct;
  int random_items;

  polyline_arclength_resample u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_vertex(in_data);
    if (rst_n && out_valid) sb.check_word(out_data);
  end

  // Presents one vertex and holds it until the block takes it.
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
    in_word_t w;
    w.point_x = x;
    w.point_y = y;
    w.last_point = last;
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_data <= in_word_t'({$urandom, $urandom, 1'b0});
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic random_polyline();
    int n;
    int kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    kind = $urandom_range(3);
    x = $urandom;
    y = $urandom;
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: begin
          x = $urandom;
          y = $urandom;
        end
        1: begin
          x = x + $signed($urandom_range(20000)) - 10000;
          y = y + $signed($urandom_range(20000)) - 10000;
        end
        2: begin
          // Tiny steps with repeats, so spacing can round to zero.
          if ($urandom_range(1)) x = x + $urandom_range(1);
          if ($urandom_range(1)) y = y - $urandom_range(1);
        end
        default: begin
          x = x + ($signed($urandom_range(255)) <<< $urandom_range(16));
          y = y - ($signed($urandom_range(255)) <<< $urandom_range(16));
        end
      endcase
      send_vertex(x, y, k == n - 1);
      random_items++;
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 27;
    random_items = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Single point, two extreme points, alternating extremes.
    send_vertex(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_vertex(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh80000000, 1'b0);
    send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b1);
    // Zero total length.
    send_vertex(32'sh00012345, -32'sh00054321, 1'b0);
    send_vertex(32'sh00012345, -32'sh00054321, 1'b0);
    send_vertex(32'sh00012345, -32'sh00054321, 1'b1);
    // Leading zero-length segment with spacing rounding to zero.
    send_vertex(0, 0, 1'b0);
    send_vertex(0, 0, 1'b0);
    send_vertex(1, 0, 1'b0);
    send_vertex(1, 0, 1'b0);
    send_vertex(1, 0, 1'b1);
    // Uneven segments on a bent path.
    send_vertex(0, 0, 1'b0);
    send_vertex(32'sh00030000, 0, 1'b0);
    send_vertex(32'sh00030000, 32'sh00010000, 1'b0);
    send_vertex(-32'sh00020000, 32'sh00050000, 1'b1);

    start <= 1'b0;
    @(posedge clk);
    while (sb.resampled_q.size() != 0) @(posedge clk);
    @(posedge clk);

    while (random_items < 80) begin
      if (random_items > 53) idle_pct = 0;
      else if (random_items > 26) idle_pct = 70;
      random_polyline();
    end
    start <= 1'b0;

    @(posedge clk);
    while (sb.resampled_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.loaded == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
